@@ design/usrd_pkg.sv @@
// ----------------------------------------------------------------------------
// USB standard request decoder package
// Shared types, request codes and the endpoint halt slot lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package usrd_pkg;

  // Number of endpoint halt bits kept by the block.
  localparam int NUM_HALT = 7;

  // Stream widths, padded to whole bytes.
  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 16;

  // Response given for one setup packet.
  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_ACK   = 3'd1,
    ACT_STALL = 3'd2,
    ACT_REPLY = 3'd3,
    ACT_APP   = 3'd4
  } action_t;

  // bmRequestType values that are decoded.
  localparam logic [7:0] RT_DEV_OUT = 8'h00;
  localparam logic [7:0] RT_IFC_OUT = 8'h01;
  localparam logic [7:0] RT_EP_OUT  = 8'h02;
  localparam logic [7:0] RT_DEV_IN  = 8'h80;
  localparam logic [7:0] RT_IFC_IN  = 8'h81;
  localparam logic [7:0] RT_EP_IN   = 8'h82;

  // bRequest values.
  localparam logic [7:0] RQ_GET_STATUS = 8'd0;
  localparam logic [7:0] RQ_CLEAR_FEAT = 8'd1;
  localparam logic [7:0] RQ_SET_FEAT   = 8'd3;
  localparam logic [7:0] RQ_GET_DESC   = 8'd6;
  localparam logic [7:0] RQ_GET_CONFIG = 8'd8;
  localparam logic [7:0] RQ_SET_CONFIG = 8'd9;
  localparam logic [7:0] RQ_GET_IFACE  = 8'd10;
  localparam logic [7:0] RQ_SET_IFACE  = 8'd11;

  // Feature selectors.
  localparam logic [15:0] FEAT_EP_HALT   = 16'd0;
  localparam logic [15:0] FEAT_WAKEUP    = 16'd1;
  localparam logic [15:0] FEAT_TEST_MODE = 16'd2;

  // One setup packet, request_type in the lowest bits.
  typedef struct packed {
    logic        app_accepts;
    logic [15:0] request_index;
    logic [15:0] request_value;
    logic [7:0]  request_code;
    logic [7:0]  request_type;
  } request_t;

  // One result item, action in the lowest bits.
  typedef struct packed {
    logic [4:0] toggle_endpoint;
    logic       toggle_reset_valid;
    logic [1:0] reply_low_byte;
    action_t    action;
  } result_t;

  // Halt slot lookup result.
  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } slot_t;

  // Map an endpoint address to its halt bit; IN and OUT share a bit except on EP1.
  function automatic slot_t halt_slot(input logic [7:0] addr);
    slot_t s;
    s.hit = 1'b1;
    s.idx = 3'd0;
    case (addr)
      8'h00, 8'h80: s.idx = 3'd0;
      8'h01:        s.idx = 3'd1;
      8'h81:        s.idx = 3'd2;
      8'h02, 8'h82: s.idx = 3'd3;
      8'h04, 8'h84: s.idx = 3'd4;
      8'h06, 8'h86: s.idx = 3'd5;
      8'h08, 8'h88: s.idx = 3'd6;
      default:      s.hit = 1'b0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ design/usrd_decode.sv @@
// ----------------------------------------------------------------------------
// USB standard request decode
// Decodes one registered setup packet and keeps the wakeup and halt state.
// ----------------------------------------------------------------------------
`default_nettype none

module usrd_decode (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,       // packet moves to the result register
  input  wire logic              self_powered,
  input  wire usrd_pkg::request_t req,
  output usrd_pkg::result_t      result
);

  logic                          remote_wakeup;
  logic                          remote_wakeup_next;
  logic [usrd_pkg::NUM_HALT-1:0] halted;
  logic [usrd_pkg::NUM_HALT-1:0] halted_next;

  usrd_pkg::slot_t               slot;
  logic [usrd_pkg::NUM_HALT-1:0] slot_mask;
  logic [7:0]                    addr;

  assign addr      = req.request_index[7:0];
  assign slot      = usrd_pkg::halt_slot(addr);
  assign slot_mask = usrd_pkg::NUM_HALT'(1) << slot.idx;

  // Request decode and next state.
  always_comb begin
    result             = '0;
    result.action      = usrd_pkg::ACT_APP;
    remote_wakeup_next = remote_wakeup;
    halted_next        = halted;

    if (req.request_type == usrd_pkg::RT_DEV_IN && req.request_code == usrd_pkg::RQ_GET_DESC) begin
      result.action = usrd_pkg::ACT_APP;
    end else if (req.request_type == usrd_pkg::RT_DEV_OUT &&
                 req.request_code == usrd_pkg::RQ_SET_CONFIG) begin
      result.action = req.app_accepts ? usrd_pkg::ACT_ACK : usrd_pkg::ACT_STALL;
    end else if (req.request_type == usrd_pkg::RT_DEV_IN &&
                 req.request_code == usrd_pkg::RQ_GET_CONFIG) begin
      result.action = usrd_pkg::ACT_APP;
    end else if (req.request_type == usrd_pkg::RT_IFC_OUT &&
                 req.request_code == usrd_pkg::RQ_SET_IFACE) begin
      result.action = req.app_accepts ? usrd_pkg::ACT_ACK : usrd_pkg::ACT_STALL;
    end else if (req.request_type == usrd_pkg::RT_IFC_IN &&
                 req.request_code == usrd_pkg::RQ_GET_IFACE) begin
      result.action = usrd_pkg::ACT_APP;
    end else if (req.request_type == usrd_pkg::RT_DEV_OUT &&
                 req.request_code == usrd_pkg::RQ_SET_FEAT) begin
      // Device feature: remote wakeup is latched, test mode is only acknowledged.
      if (req.request_value == usrd_pkg::FEAT_WAKEUP) begin
        remote_wakeup_next = 1'b1;
        result.action      = usrd_pkg::ACT_ACK;
      end else if (req.request_value == usrd_pkg::FEAT_TEST_MODE) begin
        result.action = usrd_pkg::ACT_ACK;
      end else begin
        result.action = usrd_pkg::ACT_NONE;
      end
    end else if (req.request_type == usrd_pkg::RT_DEV_IN &&
                 req.request_code == usrd_pkg::RQ_GET_STATUS) begin
      result.action         = usrd_pkg::ACT_REPLY;
      result.reply_low_byte = {remote_wakeup, self_powered};
    end else if (req.request_type == usrd_pkg::RT_IFC_IN &&
                 req.request_code == usrd_pkg::RQ_GET_STATUS) begin
      result.action = usrd_pkg::ACT_REPLY;
    end else if (req.request_type == usrd_pkg::RT_EP_OUT &&
                 (req.request_code == usrd_pkg::RQ_SET_FEAT ||
                  req.request_code == usrd_pkg::RQ_CLEAR_FEAT)) begin
      // Endpoint halt set or clear; a clear that the application accepts also resets the data toggle.
      result.action = usrd_pkg::ACT_NONE;
      if (req.request_value == usrd_pkg::FEAT_EP_HALT && slot.hit) begin
        if (req.request_code == usrd_pkg::RQ_SET_FEAT) begin
          halted_next   = halted | slot_mask;
          result.action = usrd_pkg::ACT_ACK;
        end else if (req.app_accepts) begin
          halted_next               = halted & ~slot_mask;
          result.toggle_reset_valid = 1'b1;
          result.toggle_endpoint    = {addr[7], addr[3:0]};
          result.action             = usrd_pkg::ACT_ACK;
        end else begin
          result.action = usrd_pkg::ACT_STALL;
        end
      end
    end else if (req.request_type == usrd_pkg::RT_EP_IN &&
                 req.request_code == usrd_pkg::RQ_GET_STATUS) begin
      result.action = usrd_pkg::ACT_NONE;
      if (slot.hit) begin
        result.action         = usrd_pkg::ACT_REPLY;
        result.reply_low_byte = {1'b0, halted[slot.idx]};
      end
    end
  end

  // State is committed when the packet's result is registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      remote_wakeup <= 1'b0;
      halted        <= '0;
    end else if (advance) begin
      remote_wakeup <= remote_wakeup_next;
      halted        <= halted_next;
    end
  end

endmodule

`default_nettype wire

@@ design/usb_standard_request_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// USB standard request decoder unit
// Answers USB chapter 9 standard requests from one setup packet per transfer.
// ----------------------------------------------------------------------------
// Each setup packet is taken into an input register, decoded by a short path
// against the remote-wakeup flag and seven endpoint halt bits, and its one
// result is held in an output register until the master side takes it. A new
// packet is accepted every cycle while results flow. A packet passes the input
// register and then, decoded, the output register; a stall on the master side
// can hold it in either. The self-powered bit is written over the cfg channel,
// which is always ready, and should only change while idle.
`default_nettype none

module usb_standard_request_decoder_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Setup packets: request_type[7:0], request_code[15:8], request_value[31:16],
  // request_index[47:32], app_accepts[48], zero fill above.
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [usrd_pkg::S_TDATA_W-1:0]  s_tdata,
  // Results: action[2:0], reply_low_byte[4:3], toggle_reset_valid[5],
  // toggle_endpoint[10:6], zero fill above.
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [usrd_pkg::M_TDATA_W-1:0]       m_tdata,
  // Configuration: self_powered.
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic                            cfg_data
);

  localparam int REQ_W = $bits(usrd_pkg::request_t);
  localparam int RES_W = $bits(usrd_pkg::result_t);

  logic               in_valid;
  usrd_pkg::request_t in_req;
  logic               out_valid;
  usrd_pkg::result_t  out_res;
  usrd_pkg::result_t  dec_res;
  logic               advance;
  logic               self_powered;

  // Handshake between the two register stages.
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      self_powered <= 1'b0;
    end else if (cfg_valid) begin
      self_powered <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req <= usrd_pkg::request_t'(s_tdata[REQ_W-1:0]);
    end
  end

  usrd_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .self_powered (self_powered),
    .req          (in_req),
    .result       (dec_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= dec_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(usrd_pkg::M_TDATA_W - RES_W){1'b0}}, out_res};

endmodule

`default_nettype wire

@@ tb/sv/tb_usb_standard_request_decoder_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the USB standard request decoder unit
// Drives setup packets on the slave stream and checks every result on the
// master stream against an in-bench prediction of the decoder. The prediction
// keeps its own remote-wakeup flag, endpoint halt bits and self-powered bit.
// A directed pass covers each decoded request and the corner cases, then
// random traffic runs under several idle and stall patterns, a long output
// hold-off and a full drain in the middle of a burst.
// ----------------------------------------------------------------------------
module tb_usb_standard_request_decoder_unit;
  import usrd_pkg::*;

  localparam int QUIET_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int RANDOM_BURST    = 260;

  // Endpoint addresses that own a halt bit.
  localparam logic [7:0] ENDPOINT_ADDRS [12] = '{
    8'h00, 8'h80, 8'h01, 8'h81, 8'h02, 8'h82,
    8'h04, 8'h84, 8'h06, 8'h86, 8'h08, 8'h88
  };

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_data  = 1'b0;

  // Predicted decoder state.
  logic                self_powered_bit = 1'b0;
  logic                wakeup_armed     = 1'b0;
  logic [NUM_HALT-1:0] halt_bits        = '0;

  result_t     expected_responses [$];
  int unsigned fail_count     = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        rx_hold        = 1'b0;

  usb_standard_request_decoder_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Halt bit for an endpoint address, or -1 when the address has none.
  function automatic int endpoint_slot(input logic [7:0] addr);
    case (addr)
      8'h00, 8'h80: return 0;
      8'h01:        return 1;
      8'h81:        return 2;
      8'h02, 8'h82: return 3;
      8'h04, 8'h84: return 4;
      8'h06, 8'h86: return 5;
      8'h08, 8'h88: return 6;
      default:      return -1;
    endcase
  endfunction

  // Work out the response to one setup packet and advance the predicted state.
  function automatic result_t predict_response(input request_t req);
    result_t res;
    int      slot;
    res        = '0;
    res.action = ACT_APP;
    slot       = endpoint_slot(req.request_index[7:0]);
    if ((req.request_type == RT_DEV_OUT && req.request_code == RQ_SET_CONFIG) ||
        (req.request_type == RT_IFC_OUT && req.request_code == RQ_SET_IFACE)) begin
      res.action = req.app_accepts ? ACT_ACK : ACT_STALL;
    end else if (req.request_type == RT_DEV_OUT && req.request_code == RQ_SET_FEAT) begin
      if (req.request_value == FEAT_WAKEUP) begin
        wakeup_armed = 1'b1;
        res.action   = ACT_ACK;
      end else if (req.request_value == FEAT_TEST_MODE) begin
        res.action = ACT_ACK;
      end else begin
        res.action = ACT_NONE;
      end
    end else if (req.request_type == RT_DEV_IN && req.request_code == RQ_GET_STATUS) begin
      res.action         = ACT_REPLY;
      res.reply_low_byte = {wakeup_armed, self_powered_bit};
    end else if (req.request_type == RT_IFC_IN && req.request_code == RQ_GET_STATUS) begin
      res.action = ACT_REPLY;
    end else if (req.request_type == RT_EP_OUT &&
                 (req.request_code == RQ_SET_FEAT || req.request_code == RQ_CLEAR_FEAT)) begin
      res.action = ACT_NONE;
      if (req.request_value == FEAT_EP_HALT && slot >= 0) begin
        if (req.request_code == RQ_SET_FEAT) begin
          halt_bits[3'(slot)] = 1'b1;
          res.action          = ACT_ACK;
        end else if (req.app_accepts) begin
          halt_bits[3'(slot)]    = 1'b0;
          res.toggle_reset_valid = 1'b1;
          res.toggle_endpoint    = {req.request_index[7], req.request_index[3:0]};
          res.action             = ACT_ACK;
        end else begin
          res.action = ACT_STALL;
        end
      end
    end else if (req.request_type == RT_EP_IN && req.request_code == RQ_GET_STATUS) begin
      res.action = ACT_NONE;
      if (slot >= 0) begin
        res.action         = ACT_REPLY;
        res.reply_low_byte = {1'b0, halt_bits[3'(slot)]};
      end
    end
    return res;
  endfunction

  function automatic request_t make_request(input logic [7:0] rtype, input logic [7:0] code,
                                            input logic [15:0] value, input logic [15:0] index,
                                            input logic accepts);
    request_t req;
    req.request_type  = rtype;
    req.request_code  = code;
    req.request_value = value;
    req.request_index = index;
    req.app_accepts   = accepts;
    return req;
  endfunction

  // Mostly well-formed requests with random content, some near misses and noise.
  function automatic request_t random_request();
    request_t    req;
    int unsigned pick;
    req.request_type  = 8'($urandom_range(255));
    req.request_code  = 8'($urandom_range(255));
    req.request_value = 16'($urandom_range(65535));
    req.request_index = 16'($urandom_range(65535));
    req.app_accepts   = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 70) begin
      case ($urandom_range(14))
        0:       {req.request_type, req.request_code} = {RT_DEV_IN, RQ_GET_DESC};
        1:       {req.request_type, req.request_code} = {RT_DEV_IN, RQ_GET_CONFIG};
        2:       {req.request_type, req.request_code} = {RT_IFC_IN, RQ_GET_IFACE};
        3:       {req.request_type, req.request_code} = {RT_DEV_OUT, RQ_SET_CONFIG};
        4:       {req.request_type, req.request_code} = {RT_IFC_OUT, RQ_SET_IFACE};
        5:       {req.request_type, req.request_code} = {RT_DEV_OUT, RQ_SET_FEAT};
        6:       {req.request_type, req.request_code} = {RT_DEV_OUT, RQ_CLEAR_FEAT};
        7:       {req.request_type, req.request_code} = {RT_DEV_IN, RQ_GET_STATUS};
        8:       {req.request_type, req.request_code} = {RT_IFC_IN, RQ_GET_STATUS};
        9, 10:   {req.request_type, req.request_code} = {RT_EP_OUT, RQ_SET_FEAT};
        11, 12:  {req.request_type, req.request_code} = {RT_EP_OUT, RQ_CLEAR_FEAT};
        default: {req.request_type, req.request_code} = {RT_EP_IN, RQ_GET_STATUS};
      endcase
      // Feature selectors that matter, with an occasional odd one.
      case ($urandom_range(4))
        0, 1:    req.request_value = FEAT_EP_HALT;
        2:       req.request_value = FEAT_WAKEUP;
        3:       req.request_value = FEAT_TEST_MODE;
        default: ;
      endcase
      if ($urandom_range(9) < 8)
        req.request_index[7:0] = ENDPOINT_ADDRS[4'($urandom_range(11))];
    end else if (pick < 85) begin
      // Near miss: a decoded recipient with a nearby request code.
      case ($urandom_range(5))
        0:       req.request_type = RT_DEV_OUT;
        1:       req.request_type = RT_IFC_OUT;
        2:       req.request_type = RT_EP_OUT;
        3:       req.request_type = RT_DEV_IN;
        4:       req.request_type = RT_IFC_IN;
        default: req.request_type = RT_EP_IN;
      endcase
      req.request_code = 8'($urandom_range(15));
    end
    return req;
  endfunction

  // Offer one setup packet, idling first when the phase asks for gaps.
  task automatic send_request(input request_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W - $bits(request_t)){1'b0}}, req};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_responses.push_back(predict_response(req));
  endtask

  task automatic run_random_requests(input int unsigned count);
    repeat (count) send_request(random_request());
  endtask

  // Stop offering and wait until every predicted response has been seen.
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
  endtask

  task automatic write_self_powered(input logic value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    self_powered_bit = value;
    cfg_valid <= 1'b0;
  endtask

  // Every decoded request once, then the corner cases.
  task automatic test_directed_requests();
    wait_results_drained();
    write_self_powered(1'b1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(make_request(RT_DEV_IN, RQ_GET_DESC, 16'h0100, 16'h0000, 1'b0));
    send_request(make_request(RT_DEV_IN, RQ_GET_CONFIG, 16'h0000, 16'h0000, 1'b0));
    send_request(make_request(RT_IFC_IN, RQ_GET_IFACE, 16'h0000, 16'h0001, 1'b1));
    send_request(make_request(RT_DEV_OUT, RQ_SET_CONFIG, 16'h0001, 16'h0000, 1'b1));
    send_request(make_request(RT_DEV_OUT, RQ_SET_CONFIG, 16'h0001, 16'h0000, 1'b0));
    send_request(make_request(RT_IFC_OUT, RQ_SET_IFACE, 16'h0001, 16'h0000, 1'b1));
    send_request(make_request(RT_IFC_OUT, RQ_SET_IFACE, 16'h0001, 16'h0000, 1'b0));
    send_request(make_request(RT_DEV_IN, RQ_GET_STATUS, 16'h0000, 16'h0000, 1'b0));
    send_request(make_request(RT_DEV_OUT, RQ_SET_FEAT, FEAT_TEST_MODE, 16'h0400, 1'b0));
    // An unknown device feature is ignored.
    send_request(make_request(RT_DEV_OUT, RQ_SET_FEAT, 16'hffff, 16'h0000, 1'b1));
    send_request(make_request(RT_DEV_OUT, RQ_SET_FEAT, FEAT_WAKEUP, 16'h0000, 1'b0));
    // Clear device feature goes to the application and leaves wakeup armed.
    send_request(make_request(RT_DEV_OUT, RQ_CLEAR_FEAT, FEAT_WAKEUP, 16'h0000, 1'b1));
    send_request(make_request(RT_DEV_IN, RQ_GET_STATUS, 16'h0000, 16'h0000, 1'b0));
    send_request(make_request(RT_IFC_IN, RQ_GET_STATUS, 16'h0000, 16'h0000, 1'b0));
    // EP1 IN and EP1 OUT keep separate halt bits.
    send_request(make_request(RT_EP_OUT, RQ_SET_FEAT, FEAT_EP_HALT, 16'h0081, 1'b0));
    send_request(make_request(RT_EP_IN, RQ_GET_STATUS, 16'h0000, 16'h0081, 1'b0));
    send_request(make_request(RT_EP_IN, RQ_GET_STATUS, 16'h0000, 16'h0001, 1'b0));
    send_request(make_request(RT_EP_OUT, RQ_CLEAR_FEAT, FEAT_EP_HALT, 16'h0081, 1'b0));
    send_request(make_request(RT_EP_OUT, RQ_CLEAR_FEAT, FEAT_EP_HALT, 16'h0081, 1'b1));
    // Endpoint feature other than halt, and endpoints without a halt bit.
    send_request(make_request(RT_EP_OUT, RQ_SET_FEAT, 16'h8000, 16'h0002, 1'b1));
    send_request(make_request(RT_EP_OUT, RQ_SET_FEAT, FEAT_EP_HALT, 16'h0003, 1'b1));
    send_request(make_request(RT_EP_IN, RQ_GET_STATUS, 16'h0000, 16'h00ff, 1'b0));
    // The high byte of the index is ignored.
    send_request(make_request(RT_EP_OUT, RQ_SET_FEAT, FEAT_EP_HALT, 16'hff88, 1'b0));
    send_request(make_request(RT_EP_IN, RQ_GET_STATUS, 16'hffff, 16'h7f88, 1'b1));
    send_request(make_request(8'hff, 8'hff, 16'hffff, 16'hffff, 1'b1));
  endtask

  task automatic test_random_steady();
    wait_results_drained();
    write_self_powered(1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_requests(RANDOM_BURST);
  endtask

  task automatic test_random_sender_gaps();
    wait_results_drained();
    write_self_powered(1'b1);
    send_idle_pct  = 84;
    recv_stall_pct = 0;
    run_random_requests(RANDOM_BURST);
  endtask

  task automatic test_random_receiver_stalls();
    wait_results_drained();
    write_self_powered(1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 84;
    run_random_requests(RANDOM_BURST);
  endtask

  task automatic test_random_mixed_idle();
    wait_results_drained();
    write_self_powered(1'b1);
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    run_random_requests(RANDOM_BURST);
  endtask

  // The receiver holds off while packets keep coming, so the input must stall.
  task automatic test_output_backpressure();
    wait_results_drained();
    write_self_powered(1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    run_random_requests(40);
  endtask

  // A burst, a full drain with the sender quiet, then another burst.
  task automatic test_sender_pause();
    wait_results_drained();
    write_self_powered(1'b1);
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    run_random_requests(25);
    wait_results_drained();
    run_random_requests(25);
  endtask

  // Receiver readiness, with random stalls and the long hold-off.
  always @(posedge clk) begin
    m_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each result transfer with the oldest predicted response.
  always @(posedge clk) begin : response_check
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[$bits(result_t)-1:0]);
      if (expected_responses.size() == 0) begin
        $error("unexpected result transfer, m_tdata %h", m_tdata);
        fail_count++;
      end else begin
        want = expected_responses.pop_front();
        if (got.action !== want.action) begin
          $error("action: expected %0d, actual %0d", want.action, got.action);
          fail_count++;
        end
        if (got.reply_low_byte !== want.reply_low_byte) begin
          $error("reply_low_byte: expected %0d, actual %0d",
                 want.reply_low_byte, got.reply_low_byte);
          fail_count++;
        end
        if (got.toggle_reset_valid !== want.toggle_reset_valid) begin
          $error("toggle_reset_valid: expected %0d, actual %0d",
                 want.toggle_reset_valid, got.toggle_reset_valid);
          fail_count++;
        end
        if (got.toggle_endpoint !== want.toggle_endpoint) begin
          $error("toggle_endpoint: expected %h, actual %h",
                 want.toggle_endpoint, got.toggle_endpoint);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL usb_standard_request_decoder_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_requests();
    test_random_steady();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_mixed_idle();
    test_output_backpressure();
    test_sender_pause();
    wait_results_drained();
    repeat (8) @(posedge clk);
    if (expected_responses.size() != 0) begin
      $error("%0d responses never arrived", expected_responses.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("PASS usb_standard_request_decoder_unit");
    end else begin
      $display("FAIL usb_standard_request_decoder_unit");
    end
    $finish;
  end

endmodule
